### hw/rtl/kqsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_pkg - shared definitions for the shared-buffer queue block
// Field widths, operation and status codes, and the result record handed
// from the controller to the output stage.
// ----------------------------------------------------------------------------
package kqsb_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int QID_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - STATUS_W - 1;

    localparam int SLOTS_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    // operation codes; the unused code behaves as a peek
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] ERR_WORD = {DATA_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0]   data;
        logic        [STATUS_W-1:0] status;
        logic                       empty;
    } result_t;

endpackage

### hw/rtl/kqsb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// until the next read is issued.
// ----------------------------------------------------------------------------
module kqsb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/kqsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_ctrl - queue controller with slot, link and queue-pointer memories
// Reads the queue pointers and the free-list link, then modifies and writes
// back. Never-used slots are handed out by a fill counter, so the link
// memory needs no initialisation.
// ----------------------------------------------------------------------------
module kqsb_ctrl
    import kqsb_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        in_mode,
    input  logic [QID_W-1:0]         in_qid,
    input  logic signed [DATA_W-1:0] in_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res
);

    localparam int PW  = $clog2(SLOTS + 1);
    localparam int SAW = $clog2(SLOTS);
    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_QRD  = 2'd1;
    localparam logic [1:0] S_SRD  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [QID_W-1:0]         qid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [PW-1:0]            free_head_reg, free_head_next;
    logic [PW-1:0]            fresh_reg, fresh_next;
    logic [QUEUES-1:0]        nonempty_reg, nonempty_next;

    logic              accept;
    logic [QW-1:0]     qidx;
    logic              q_err;
    logic              nonempty;
    logic [PW-1:0]     head, tail;
    logic              fwd;

    logic              data_we, data_re;
    logic [SAW-1:0]    data_waddr;
    logic [DATA_W-1:0] data_rdata;
    logic              link_we, link_re;
    logic [SAW-1:0]    link_waddr, link_raddr;
    logic [PW-1:0]     link_wdata, link_rdata;
    logic              q_we;
    logic [2*PW-1:0]   q_wdata, q_rdata;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign qidx     = QW'(qid_reg);
    assign q_err    = (32'(qid_reg) >= QUEUES);
    assign nonempty = nonempty_reg[qidx];
    assign head     = q_rdata[2*PW-1:PW];
    assign tail     = q_rdata[PW-1:0];

    // pop or peek on a filled queue goes on to read the head slot
    assign fwd = (state_reg == S_QRD) && (mode_reg != MODE_PUSH) && !q_err && nonempty;

    // link reads: free-list head at accept, queue head afterwards
    assign link_re    = accept || fwd;
    assign link_raddr = (state_reg == S_IDLE) ? SAW'(free_head_reg) : SAW'(head);
    assign data_re    = fwd;

    // capture the beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_mode;
            qid_reg   <= in_qid;
            value_reg <= in_value;
        end
    end

    // sequencer and pointer updates
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        nonempty_next  = nonempty_reg;
        res_valid      = 1'b0;
        res.data       = ERR_WORD;
        res.status     = ST_OK;
        res.empty      = 1'b1;
        data_we        = 1'b0;
        data_waddr     = SAW'(free_head_reg);
        link_we        = 1'b0;
        link_waddr     = SAW'(tail);
        link_wdata     = free_head_reg;
        q_we           = 1'b0;
        q_wdata        = {head, tail};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                if (fwd)
                begin
                    state_next = S_SRD;
                end
                else
                begin
                    res_valid = 1'b1;
                    if (q_err)
                    begin
                        res.status = (mode_reg == MODE_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
                    end
                    else if (mode_reg != MODE_PUSH)
                    begin
                        res.status = ST_UNDERFLOW;
                    end
                    else if (free_head_reg == NIL)
                    begin
                        res.status = ST_OVERFLOW;
                        res.empty  = !nonempty;
                    end
                    else
                    begin
                        res.data   = '0;
                        res.status = ST_OK;
                        res.empty  = 1'b0;
                        if (res_ready)
                        begin
                            // take the free slot and append it at the tail
                            if (free_head_reg == fresh_reg)
                            begin
                                free_head_next = free_head_reg + PW'(1);
                                fresh_next     = fresh_reg + PW'(1);
                            end
                            else
                            begin
                                free_head_next = link_rdata;
                            end
                            data_we     = 1'b1;
                            link_we     = nonempty;
                            link_wdata  = free_head_reg;
                            q_we        = 1'b1;
                            q_wdata     = {(nonempty ? head : free_head_reg), free_head_reg};
                            nonempty_next[qidx] = 1'b1;
                        end
                    end
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SRD:
            begin
                res_valid  = 1'b1;
                res.data   = data_rdata;
                res.status = ST_OK;
                res.empty  = (mode_reg == MODE_POP) && (head == tail);
                if (res_ready)
                begin
                    state_next = S_IDLE;
                    if (mode_reg == MODE_POP)
                    begin
                        // return the head slot to the front of the free list
                        link_we        = 1'b1;
                        link_waddr     = SAW'(head);
                        link_wdata     = free_head_reg;
                        free_head_next = head;
                        if (head == tail)
                        begin
                            nonempty_next[qidx] = 1'b0;
                        end
                        else
                        begin
                            q_we    = 1'b1;
                            q_wdata = {link_rdata, tail};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            nonempty_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            nonempty_reg  <= nonempty_next;
        end
    end

    // slot payload store
    kqsb_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (SLOTS),
        .ADDR_W (SAW)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (value_reg),
        .re    (data_re),
        .raddr (SAW'(head)),
        .rdata (data_rdata)
    );

    // per-slot next links
    kqsb_ram #(
        .WIDTH  (PW),
        .DEPTH  (SLOTS),
        .ADDR_W (SAW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // queue head and tail pointers
    kqsb_ram #(
        .WIDTH  (2 * PW),
        .DEPTH  (QUEUES),
        .ADDR_W (QW)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (qidx),
        .wdata (q_wdata),
        .re    (accept),
        .raddr (QW'(in_qid)),
        .rdata (q_rdata)
    );

    // the head slot is only read straight after the pointer read
    a_srd_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRD) |-> ($past(state_reg) == S_QRD || $past(state_reg) == S_SRD))
        else $error("slot read state entered out of order");

    // pointers never run past null
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg <= NIL) && (fresh_reg <= NIL))
        else $error("free-list pointer or fill count out of range");

    // a result is offered only while an operation is under way
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (state_reg != S_IDLE))
        else $error("result offered while idle");

    // a completed pop puts its slot at the front of the free list
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRD && res_ready && mode_reg == MODE_POP) |=>
            (free_head_reg == $past(head)))
        else $error("popped slot not returned to the free list");

endmodule

### hw/rtl/k_queues_shared_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_queues_shared_buffer - several FIFO queues sharing one slot store
// Push, pop and peek on QUEUES linked-list queues held in SLOTS shared slots.
//
// Usage:
//   s_* carries one operation per beat; every operation yields exactly one
//   result beat on m_*. s_tready is high while the controller is idle.
//   Push and error cases finish after the queue-pointer read; pop and
//   peek go on to the slot read, since the slot read depends on the
//   queue-pointer read and the memories have a single read port each.
//   With no receiver stall the next operation is accepted at the edge
//   where the previous result can be taken.
//   The result sits in an output register, so a finished result may wait
//   for m_tready while the next operation is accepted. When the receiver
//   stalls with a result pending, the following operation waits at its
//   final step without touching the memories until the register frees.
//   Reset empties every queue and rebuilds the free list at once through
//   a fill counter: no clearing pass, operations may start as soon as
//   reset is released.
// ----------------------------------------------------------------------------
module k_queues_shared_buffer
    import kqsb_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode[1:0], queue_id[3:2], value[35:4]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // data_out[31:0], status[33:32], queue_empty[34]
);

    logic    res_valid, res_ready;
    result_t res;
    logic    m_tvalid_reg;
    result_t out_reg;

    // unpack the operation beat
    kqsb_ctrl #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[MODE_W-1:0]),
        .in_qid    (s_tdata[MODE_W+QID_W-1:MODE_W]),
        .in_value  (s_tdata[MODE_W+QID_W+DATA_W-1:MODE_W+QID_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.empty, out_reg.status, out_reg.data};

endmodule

### sim/kqsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_checker - result scoreboard for the shared-buffer queue block
// Watches both stream channels. Every accepted operation beat is run through
// a local copy of the queue state, which includes the free list, head and tail
// pointers and slot links. The predicted result is queued, and each accepted
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kqsb_checker
    import kqsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode[1:0], queue_id[3:2], value[35:4]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // data_out[31:0], status[33:32], queue_empty[34]
    output int                     fail_count,
    output int                     outstanding
);

    localparam int SLOTS  = SLOTS_DEF;
    localparam int QUEUES = QUEUES_DEF;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int SIDX_W = $clog2(SLOTS);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [SIDX_W-1:0] sidx_t;

    localparam ptr_t NIL = ptr_t'(SLOTS);

    // shadow copy of the block's queue state
    logic [DATA_W-1:0] slot_word [SLOTS];
    ptr_t              next_slot [SLOTS];
    ptr_t              head_ptr  [QUEUES];
    ptr_t              tail_ptr  [QUEUES];
    ptr_t              free_ptr;

    result_t predicted_results [$];

    // rebuild the free list and empty every queue
    task automatic clear_queues();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_word[i] = '0;
            next_slot[i] = ptr_t'(i + 1);
        end
        next_slot[SLOTS-1] = NIL;
        for (int i = 0; i < QUEUES; i++)
        begin
            head_ptr[i] = NIL;
            tail_ptr[i] = NIL;
        end
        free_ptr = '0;
    endtask

    // apply one operation to the shadow state and work out its result
    task automatic predict_queue_op(
        input  logic [MODE_W-1:0] mode,
        input  logic [QID_W-1:0]  qid,
        input  logic [DATA_W-1:0] word,
        output result_t           res
    );
        ptr_t slot;
        int   q;
        q = int'(qid);
        res.data   = ERR_WORD;
        res.status = ST_OK;
        res.empty  = 1'b1;
        if (q >= QUEUES)
        begin
            // queue out of range: report an error, leave the state alone
            res.status = (mode == MODE_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
        end
        else if (mode == MODE_PUSH)
        begin
            if (free_ptr == NIL)
            begin
                res.status = ST_OVERFLOW;
                res.empty  = (head_ptr[qid] == NIL);
            end
            else
            begin
                // take the first free slot and link it in at the tail
                slot     = free_ptr;
                free_ptr = next_slot[sidx_t'(slot)];
                if (head_ptr[qid] == NIL)
                    head_ptr[qid] = slot;
                else
                    next_slot[sidx_t'(tail_ptr[qid])] = slot;
                tail_ptr[qid]             = slot;
                slot_word[sidx_t'(slot)] = word;
                next_slot[sidx_t'(slot)] = NIL;
                res.data  = '0;
                res.empty = 1'b0;
            end
        end
        else
        begin
            slot = head_ptr[qid];
            if (slot == NIL)
            begin
                res.status = ST_UNDERFLOW;
            end
            else if (mode == MODE_POP)
            begin
                // unlink the head and return its slot to the front of the free list
                head_ptr[qid] = next_slot[sidx_t'(slot)];
                if (head_ptr[qid] == NIL)
                    tail_ptr[qid] = NIL;
                next_slot[sidx_t'(slot)] = free_ptr;
                free_ptr                 = slot;
                res.data  = slot_word[sidx_t'(slot)];
                res.empty = (head_ptr[qid] == NIL);
            end
            else
            begin
                // peek, and the spare code behaves the same
                res.data  = slot_word[sidx_t'(slot)];
                res.empty = 1'b0;
            end
        end
    endtask

    // check result beats first, then predict the operation beat of this edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            clear_queues();
            predicted_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.data   = m_tdata[DATA_W-1:0];
                got.status = m_tdata[DATA_W +: STATUS_W];
                got.empty  = m_tdata[DATA_W + STATUS_W];
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with none pending: data_out %0d status %0d",
                           got.data, got.status);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("data_out: expected %0d, got %0d", want.data, got.data);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.empty !== want.empty)
                    begin
                        $error("queue_empty: expected %0d, got %0d", want.empty, got.empty);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_queue_op(s_tdata[MODE_W-1:0], s_tdata[MODE_W +: QID_W],
                                 s_tdata[MODE_W + QID_W +: DATA_W], want);
                predicted_results.push_back(want);
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the shared-buffer queue block
// Drives push, pop and peek beats: a directed opening that covers empty
// queues, extreme words, a full store and overflow, then phases that favour
// filling or draining. Both sides idle in random bursts, and one long receiver
// stall backs the block up. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import kqsb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_OPS = 650;
    localparam int CALM_TAIL  = 100;
    localparam int LONG_HOLD  = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // mode[1:0], queue_id[3:2], value[35:4]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // data_out[31:0], status[33:32], queue_empty[34]

    int fail_count;
    int outstanding;

    bit tx_idle_en;
    bit rx_idle_en;
    int hold_requests;

    k_queues_shared_buffer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kqsb_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        int holds_served;
        m_tready     = 1'b0;
        stall_left   = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && hold_requests != holds_served)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one operation beat and hold it until accepted; returns at a falling edge
    task automatic send_op(
        input logic [MODE_W-1:0] mode,
        input logic [QID_W-1:0]  qid,
        input logic [DATA_W-1:0] word
    );
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - MODE_W - QID_W - DATA_W){1'b0}}, word, qid, mode};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // data word, biased towards the extremes
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // stimulus
    initial
    begin
        int push_pct;
        int pop_pct;
        int r;
        logic [MODE_W-1:0] mode;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_requests = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // empty queues, every code
        send_op(MODE_POP,   2'd0, 32'h1234_5678);
        send_op(MODE_PEEK,  2'd3, '1);
        send_op(MODE_SPARE, 2'd1, '0);
        send_op(MODE_PUSH,  2'd0, 32'h7FFF_FFFF);
        send_op(MODE_PUSH,  2'd0, 32'h8000_0000);
        send_op(MODE_PEEK,  2'd0, '0);
        send_op(MODE_SPARE, 2'd0, '1);
        send_op(MODE_POP,   2'd0, '0);
        // fill the store, then overflow
        for (int i = 0; i < 15; i++)
            send_op(MODE_PUSH, QID_W'(i % 4), (i % 3 == 0) ? '1 : $urandom());
        send_op(MODE_PUSH, 2'd1, 32'h5555_AAAA);
        send_op(MODE_POP,  2'd0, '1);

        // random phases: fill, drain, balanced, peek heavy
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            case ((i / 40) % 4)
                0:       begin push_pct = 75; pop_pct = 15; end
                1:       begin push_pct = 15; pop_pct = 75; end
                2:       begin push_pct = 45; pop_pct = 45; end
                default: begin push_pct = 40; pop_pct = 30; end
            endcase
            if (i == RANDOM_OPS / 2)
                hold_requests++;
            if (i == RANDOM_OPS - CALM_TAIL)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < push_pct)
                mode = MODE_PUSH;
            else if (r < push_pct + pop_pct)
                mode = MODE_POP;
            else if ($urandom_range(0, 1) == 0)
                mode = MODE_PEEK;
            else
                mode = MODE_SPARE;
            send_op(mode, QID_W'($urandom_range(0, 3)), pick_word());
        end
        s_tvalid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
